// File: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg - shared definitions for the positional list engine
// Operation and status codes, field widths and the control word that is
// broadcast along the row of storage cells.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Fixed field widths of the request and response channels.
    localparam int FUNC_W = 3;
    localparam int POS_W  = 8;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 2;

    // Defaults for the top-level parameters.
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Wide enough for any cell index or fill level up to the largest capacity.
    localparam int AT_W = 11;

    // Cells per group of the removed-value OR tree.
    localparam int GROUP = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND     = 3'd0,
        FN_POP_BACK   = 3'd1,
        FN_PUSH_FRONT = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_INSERT_AT  = 3'd4,
        FN_ERASE_AT   = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast to every cell: shift right from 'at' (insert) or shift left
    // from 'at' (remove). At most one of ins and rem is set.
    typedef struct packed {
        logic            ins;
        logic            rem;
        logic [AT_W-1:0] at;
    } t_cell_ctl;

endpackage

// File: rtl/ple_if.sv
// ----------------------------------------------------------------------------
// ple_if - request and response channels of the positional list engine
// Valid/ready channels; a transfer happens on a rising edge with both high.
// ----------------------------------------------------------------------------
interface ple_req_if;
    import ple_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface ple_rsp_if;
    import ple_pkg::*;

    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  removed_value;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;

    modport source (output valid, output removed_value, output count, output status,
                    input ready);
    modport sink   (input valid, input removed_value, input count, input status,
                    output ready);
endinterface

// File: rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell - one storage slot of the list
// Holds one element and takes its left or right neighbor's element, the new
// value, or keeps its own, by comparing its index with the broadcast position.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  ple_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_new,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_tap
);
    import ple_pkg::*;

    localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX > i_ctl.at) begin
                n_data = i_left;
            end else if (MY_IDX == i_ctl.at) begin
                n_data = i_new;
            end
        end else if (i_ctl.rem && (MY_IDX >= i_ctl.at)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // The element being removed leaves through this tap; all others give zero.
    assign o_tap  = (i_ctl.rem && (MY_IDX == i_ctl.at)) ? r_data : '0;

endmodule

// File: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine - bounded ordered list with positional insert/erase
// A row of CAPACITY cells holds the list, element i in cell i. A legal
// insert or removal moves the row one place; each request gets one response.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload                          | handshake
//   --------+-----------+----------------------------------+-------------
//   i_req   | in        | func, position, value            | valid/ready
//   o_rsp   | out       | removed_value, count, status     | valid/ready
//
// A request transfer updates the cell row and the fill level at once. Its
// response is registered in the middle stage and then, once the output
// register is free, in the output register, because the removed element
// passes through a two-level OR tree that is registered after each level
// (groups of 32 cells, then across the groups). One request per cycle is
// sustained while the response side keeps taking transfers. A response that
// is stalled holds in the output register; one more request is still
// accepted into the middle stage before i_req.ready drops. Reset
// (synchronous, active low) empties the list and both stages; cell contents
// are not cleared, since a slot is only read after it has been written.
//
module positional_list_engine #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ple_req_if.sink   i_req,
    ple_rsp_if.source o_rsp
);
    import ple_pkg::*;

    localparam int FW   = $clog2(CAPACITY + 1);
    localparam int NGRP = (CAPACITY + GROUP - 1) / GROUP;

    // Fill level and pipeline control.
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic          r_stg_v;
    logic          n_stg_v;
    logic          r_out_v;
    logic          n_out_v;

    // Middle stage: response fields and the per-group OR of the removed tap.
    logic [CNT_W-1:0]      r_stg_count;
    t_status               r_stg_status;
    logic [DATA_WIDTH-1:0] r_grp [NGRP];

    // Output register.
    logic [VAL_W-1:0]  r_out_removed;
    logic [CNT_W-1:0]  r_out_count;
    t_status           r_out_status;

    // Decode.
    logic            w_fire;
    logic            w_move;
    logic            w_ins_req;
    logic            w_rem_req;
    logic [AT_W-1:0] w_at;
    logic [AT_W-1:0] w_fill_x;
    logic [AT_W-1:0] w_pos_x;
    logic            w_full;
    logic            w_bad_rem;
    t_status         w_status;
    t_cell_ctl       w_ctl;

    // Cell row.
    logic [DATA_WIDTH-1:0] w_new;
    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_tap  [CAPACITY];
    logic [DATA_WIDTH-1:0] w_grp  [NGRP];
    logic [DATA_WIDTH-1:0] w_rem_or;
    logic [63:0]           w_val64;
    logic [63:0]           w_rem64;

    // ------------------------------------------------------------------------
    // Handshake. The middle stage drains into the output register when that
    // register is empty or is being emptied in the same cycle.
    // ------------------------------------------------------------------------
    assign w_move      = r_stg_v && (!r_out_v || o_rsp.ready);
    assign i_req.ready = !r_stg_v || w_move;
    assign w_fire      = i_req.valid && i_req.ready;

    // ------------------------------------------------------------------------
    // Operation decode: which way the row shifts and from which position.
    // ------------------------------------------------------------------------
    assign w_fill_x = AT_W'(r_fill);
    assign w_pos_x  = AT_W'(i_req.position);

    always_comb begin
        w_ins_req = 1'b0;
        w_rem_req = 1'b0;
        w_at      = '0;
        unique case (t_func'(i_req.func))
            FN_APPEND: begin
                w_ins_req = 1'b1;
                w_at      = w_fill_x;
            end
            FN_PUSH_FRONT: begin
                w_ins_req = 1'b1;
            end
            FN_INSERT_AT: begin
                // A position past the count lands at the back.
                w_ins_req = 1'b1;
                w_at      = (w_pos_x > w_fill_x) ? w_fill_x : w_pos_x;
            end
            FN_POP_BACK: begin
                // On an empty list this wraps, but the empty check rejects it.
                w_rem_req = 1'b1;
                w_at      = w_fill_x - AT_W'(1);
            end
            FN_POP_FRONT: begin
                w_rem_req = 1'b1;
            end
            FN_ERASE_AT: begin
                w_rem_req = 1'b1;
                w_at      = w_pos_x;
            end
            default: begin
                // Unused selectors leave the list alone and report done.
            end
        endcase
    end

    assign w_full    = (r_fill == FW'(CAPACITY));
    assign w_bad_rem = (r_fill == '0) || (w_at >= w_fill_x);

    always_comb begin
        if (w_ins_req && w_full) begin
            w_status = ST_FULL;
        end else if (w_rem_req && w_bad_rem) begin
            w_status = ST_EMPTY;
        end else begin
            w_status = ST_DONE;
        end
    end

    // Only an accepted and legal operation reaches the cells.
    assign w_ctl.ins = w_fire && w_ins_req && !w_full;
    assign w_ctl.rem = w_fire && w_rem_req && !w_bad_rem;
    assign w_ctl.at  = w_at;

    always_comb begin
        n_fill = r_fill;
        if (w_ctl.ins) begin
            n_fill = r_fill + FW'(1);
        end else if (w_ctl.rem) begin
            n_fill = r_fill - FW'(1);
        end
    end

    // ------------------------------------------------------------------------
    // Cell row. Each cell sees its two neighbors; the ends see themselves,
    // which only matters for slots that hold no element.
    // ------------------------------------------------------------------------
    assign w_val64 = 64'(i_req.value);
    assign w_new   = w_val64[DATA_WIDTH-1:0];

    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_new   (w_new),
            .i_left  (w_data[(c == 0) ? 0 : c - 1]),
            .i_right (w_data[(c == CAPACITY - 1) ? c : c + 1]),
            .o_data  (w_data[c]),
            .o_tap   (w_tap[c])
        );
    end

    // First level of the removed-value tree: OR within each group of cells.
    // At most one tap in the whole row is nonzero.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < CAPACITY) begin
                    w_grp[g] = w_grp[g] | w_tap[g * GROUP + k];
                end
            end
        end
    end

    // Second level: OR across the registered group results.
    always_comb begin
        w_rem_or = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_rem_or = w_rem_or | r_grp[g];
        end
    end

    assign w_rem64 = 64'(w_rem_or);

    // ------------------------------------------------------------------------
    // Stage valid bits.
    // ------------------------------------------------------------------------
    always_comb begin
        n_stg_v = r_stg_v;
        if (w_fire) begin
            n_stg_v = 1'b1;
        end else if (w_move) begin
            n_stg_v = 1'b0;
        end
    end

    always_comb begin
        n_out_v = r_out_v;
        if (w_move) begin
            n_out_v = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_stg_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_stg_v <= n_stg_v;
            r_out_v <= n_out_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_stg_count  <= CNT_W'(n_fill);
            r_stg_status <= w_status;
            for (int g = 0; g < NGRP; g++) begin
                r_grp[g] <= w_grp[g];
            end
        end
        if (w_move) begin
            r_out_removed <= w_rem64[VAL_W-1:0];
            r_out_count   <= r_stg_count;
            r_out_status  <= r_stg_status;
        end
    end

    assign o_rsp.valid         = r_out_v;
    assign o_rsp.removed_value = r_out_removed;
    assign o_rsp.count         = r_out_count;
    assign o_rsp.status        = r_out_status;

endmodule

// File: rtl/ple_chk.sv
// ----------------------------------------------------------------------------
// ple_chk - port-level checks for the positional list engine
// Watches the response channel; bound to the top level below.
// ----------------------------------------------------------------------------
module ple_chk #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [ple_pkg::VAL_W-1:0]  i_removed_value,
    input logic [ple_pkg::CNT_W-1:0]  i_count,
    input logic [ple_pkg::STAT_W-1:0] i_status
);
    import ple_pkg::*;

    // A rejected insert leaves a full list and removes nothing.
    a_full_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_FULL)) |->
            ((i_removed_value == '0) && (i_count == CNT_W'(CAPACITY))))
        else $error("full response with bad count or removed value");

    // A failed removal returns zero.
    a_empty_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_EMPTY)) |-> (i_removed_value == '0))
        else $error("failed removal returned a value");

    // The count never passes the capacity (both compared at AT_W bits).
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (AT_W'(i_count) <= AT_W'(CAPACITY)))
        else $error("count beyond capacity");

    // A stalled response stays and holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_removed_value) && $stable(i_count)
             && $stable(i_status)))
        else $error("stalled response changed");

endmodule

bind positional_list_engine ple_chk #(
    .CAPACITY (CAPACITY)
) u_ple_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_removed_value (o_rsp.removed_value),
    .i_count         (o_rsp.count),
    .i_status        (o_rsp.status)
);

// File: tb/sv/tb_positional_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine - self-checking bench for the positional list engine
// Sends list operations through the request channel with random gaps. A
// shadow copy of the list predicts every response, and each response is
// compared with the oldest prediction. The response side stalls at random,
// and once for a long stretch, so that the engine fills up and holds off.
// ----------------------------------------------------------------------------

module tb_positional_list_engine;
    import ple_pkg::*;

    localparam int  LIST_CAP    = CAPACITY_DEF;
    localparam int  HOLD_CYCLES = 90;
    localparam int  ITEM_TARGET = 800;
    // The selector has two codes with no operation behind them.
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    // Keeps a shadow of the list contents and the responses still to arrive.
    class list_scoreboard;
        typedef struct packed {
            logic [VAL_W-1:0] removed_value;
            logic [CNT_W-1:0] count;
            t_status          status;
        } t_list_rsp;

        int               capacity;
        logic [VAL_W-1:0] shadow_elems[$];
        t_list_rsp        expected_rsps[$];
        int               errors;

        function new(int cap);
            capacity = cap;
            errors   = 0;
        endfunction

        function int fill();
            return shadow_elems.size();
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction

        // Inserts at a clamped position; a full list rejects the element.
        function t_status insert_elem(int at, logic [VAL_W-1:0] val);
            if (shadow_elems.size() >= capacity) begin
                return ST_FULL;
            end
            if (at > shadow_elems.size()) begin
                at = shadow_elems.size();
            end
            shadow_elems.insert(at, val);
            return ST_DONE;
        endfunction

        // Removes one element; an empty list or a position past the end is refused.
        function t_status remove_elem(int at, output logic [VAL_W-1:0] got);
            got = '0;
            if (shadow_elems.size() == 0 || at >= shadow_elems.size()) begin
                return ST_EMPTY;
            end
            got = shadow_elems[at];
            shadow_elems.delete(at);
            return ST_DONE;
        endfunction

        // Applies one accepted request to the shadow and queues its response.
        function void note_request(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                                   logic [VAL_W-1:0] val);
            t_list_rsp        rsp;
            logic [VAL_W-1:0] got;
            int               last;
            got        = '0;
            rsp.status = ST_DONE;
            last       = (shadow_elems.size() == 0) ? 0 : shadow_elems.size() - 1;
            case (fn)
                FN_APPEND:     rsp.status = insert_elem(shadow_elems.size(), val);
                FN_POP_BACK:   rsp.status = remove_elem(last, got);
                FN_PUSH_FRONT: rsp.status = insert_elem(0, val);
                FN_POP_FRONT:  rsp.status = remove_elem(0, got);
                FN_INSERT_AT:  rsp.status = insert_elem(int'(pos), val);
                FN_ERASE_AT:   rsp.status = remove_elem(int'(pos), got);
                default:       rsp.status = ST_DONE;
            endcase
            rsp.removed_value = got;
            rsp.count         = CNT_W'(shadow_elems.size());
            expected_rsps.insert(expected_rsps.size(), rsp);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        task check_response(logic [VAL_W-1:0] removed_value, logic [CNT_W-1:0] count,
                            logic [STAT_W-1:0] status);
            t_list_rsp exp;
            if (expected_rsps.size() == 0) begin
                report_mismatch("response transfer with no request outstanding");
                return;
            end
            exp = expected_rsps.pop_front();
            if (removed_value !== exp.removed_value) begin
                report_mismatch($sformatf("removed_value got %h want %h",
                                          removed_value, exp.removed_value));
            end
            if (count !== exp.count) begin
                report_mismatch($sformatf("count got %0d want %0d", count, exp.count));
            end
            if (status !== exp.status) begin
                report_mismatch($sformatf("status got %0d want %0d", status, exp.status));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    ple_req_if req_if ();
    ple_rsp_if rsp_if ();

    positional_list_engine #(
        .CAPACITY   (LIST_CAP),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    list_scoreboard sb = new(LIST_CAP);

    // Set by the stimulus when it wants the response side to hold off for a
    // long stretch; the receiver clears it once the stretch is over.
    bit hold_request = 1'b0;

    // Windows in which one side runs without any idle cycle at all.
    int tx_steady_left = 0;
    int rx_steady_left = 0;
    int items_sent     = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic int tx_gap();
        if (tx_steady_left > 0) begin
            tx_steady_left--;
            return 0;
        end
        if ($urandom_range(99) < 4) begin
            tx_steady_left = $urandom_range(10, 40);
            return 0;
        end
        return idle_length();
    endfunction

    // Offers one request and waits for its transfer. The task is entered and
    // left on a falling edge, so all inputs change away from the sampling edge.
    // A request that follows without a gap keeps valid high and only swaps the
    // payload.
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid    = 1'b1;
        req_if.func     = fn;
        req_if.position = pos;
        req_if.value    = val;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(fn, pos, val);
        items_sent++;
        @(negedge i_clk);
    endtask

    // One random operation; grow_pct is the chance that it adds an element.
    // Positions mostly fall around the current fill so that both the in-range
    // and the just-past-the-end cases come up often.
    task automatic send_random(input int grow_pct);
        t_func            grow_ops[3];
        t_func            shrink_ops[3];
        logic [FUNC_W-1:0] fn;
        logic [POS_W-1:0]  pos;
        int                n;
        grow_ops   = '{FN_APPEND, FN_PUSH_FRONT, FN_INSERT_AT};
        shrink_ops = '{FN_POP_BACK, FN_POP_FRONT, FN_ERASE_AT};
        n = sb.fill();
        if ($urandom_range(99) < grow_pct) begin
            fn = grow_ops[$urandom_range(2)];
        end else begin
            fn = shrink_ops[$urandom_range(2)];
        end
        if ($urandom_range(9) < 8) begin
            pos = POS_W'($urandom_range(0, n + 1));
        end else begin
            pos = POS_W'($urandom_range(0, 255));
        end
        send_request(fn, pos, $urandom());
    endtask

    // Response side: random stalls, steady windows, and the one long hold.
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                // Long hold-off: the output stage and the middle stage fill,
                // after which the request side has to drop ready.
                rsp_if.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (stall_left > 0) begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end else if (rx_steady_left > 0) begin
                rsp_if.ready = 1'b1;
                rx_steady_left--;
            end else if ($urandom_range(99) < 4) begin
                rsp_if.ready   = 1'b1;
                rx_steady_left = $urandom_range(10, 40);
            end else if ($urandom_range(99) < 60) begin
                rsp_if.ready = 1'b1;
            end else begin
                rsp_if.ready = 1'b0;
                stall_left   = idle_length();
            end
        end
    end

    // Every response transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_response(rsp_if.removed_value, rsp_if.count, rsp_if.status);
        end
    end

    // Stimulus.
    initial begin
        int grow_choices[4];
        int block_len;
        int grow_pct;
        grow_choices    = '{20, 50, 80, 95};
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.func     = FN_APPEND;
        req_if.position = '0;
        req_if.value    = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Removing from the empty list, in every form.
        send_request(FN_POP_BACK,   8'd0,   32'h0);
        send_request(FN_POP_FRONT,  8'd0,   32'h0);
        send_request(FN_ERASE_AT,   8'd0,   32'h0);
        send_request(FN_ERASE_AT,   8'd255, 32'h0);
        // Build a short list with extreme values, then take it apart again.
        send_request(FN_APPEND,     8'd0,   32'h0000_0000);
        send_request(FN_APPEND,     8'd0,   32'hFFFF_FFFF);
        send_request(FN_PUSH_FRONT, 8'd0,   32'hA5A5_5A5A);
        send_request(FN_INSERT_AT,  8'd1,   32'h1234_5678);
        send_request(FN_INSERT_AT,  8'd0,   32'h8000_0001);
        // An insert far past the count lands at the back.
        send_request(FN_INSERT_AT,  8'd255, 32'h7FFF_FFFE);
        send_request(FN_INSERT_AT,  8'd7,   32'h0F0F_F0F0);
        // Erase at the count and far past it: refused, list unchanged.
        send_request(FN_ERASE_AT,   8'd7,   32'h0);
        send_request(FN_ERASE_AT,   8'd255, 32'hFFFF_FFFF);
        // The unused selector codes do nothing.
        send_request(FN_SPARE_LO,   8'd3,   32'hDEAD_BEEF);
        send_request(FN_SPARE_HI,   8'd255, 32'hFFFF_FFFF);
        send_request(FN_ERASE_AT,   8'd2,   32'h0);
        send_request(FN_ERASE_AT,   8'd0,   32'h0);
        send_request(FN_POP_FRONT,  8'd0,   32'h0);
        send_request(FN_POP_BACK,   8'd0,   32'h0);
        send_request(FN_ERASE_AT,   8'd1,   32'h0);
        send_request(FN_POP_BACK,   8'd0,   32'h0);
        send_request(FN_POP_BACK,   8'd0,   32'h0);

        // Fill to capacity while the response side holds off; the sender
        // keeps offering back to back so that the engine backs up.
        hold_request   = 1'b1;
        tx_steady_left = 30;
        while (sb.fill() < LIST_CAP) begin
            send_random(100);
        end
        // Further random inserts on the full list are all rejected.
        repeat (6) send_random(100);

        // Random blocks that drift the fill up and down across the range.
        while (items_sent < ITEM_TARGET) begin
            block_len = $urandom_range(20, 60);
            grow_pct  = grow_choices[$urandom_range(3)];
            repeat (block_len) send_random(grow_pct);
        end
        req_if.valid = 1'b0;

        // Drain, then allow for the two-stage response path.
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Far beyond the slowest correct run of this stimulus.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
